[rtl/k_subset_sum_counter_unit_assert.svh]
// ----------------------------------------------------------------------------
// k_subset_sum_counter_unit_assert.svh
// Assertion macros shared by the k-subset sum counter modules.
// ----------------------------------------------------------------------------
`ifndef K_SUBSET_SUM_COUNTER_UNIT_ASSERT_SVH
`define K_SUBSET_SUM_COUNTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define KSSC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define KSSC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/kssc_pkg.sv]
// ----------------------------------------------------------------------------
// kssc_pkg
// Shared widths, register indexes, sequencer states and control bundle of
// the k-subset sum counter.
// ----------------------------------------------------------------------------
package kssc_pkg;

  // Default table bounds
  localparam int MAX_K_DEF      = 8;
  localparam int MAX_TARGET_DEF = 255;

  // Field widths
  localparam int VALUE_W   = 16;
  localparam int PICK_W    = 4;
  localparam int GOAL_W    = 8;
  localparam int COUNT_W   = 32;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_SUM   = 1'd1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_SWEEP,
    ST_DRAIN,
    ST_FINISH,
    ST_RDWAIT,
    ST_RESULT
  } kssc_state_t;

  // Controls from the sequencer to the update stage
  typedef struct packed {
    logic upd_issue;  // read pair issued this cycle, write back next cycle
    logic clr_wr;     // clearing write at the sequencer address
    logic clr_one;    // clearing write stores one instead of zero
    logic sat_clr;    // drop the sticky saturation flag
  } kssc_wr_ctl_t;

endpackage

[rtl/kssc_mem.sv]
// ----------------------------------------------------------------------------
// kssc_mem
// Way table storage: two registered read ports and one write port.
// ----------------------------------------------------------------------------
module kssc_mem #(
  parameter int DEPTH = 2304,
  parameter int AW    = 12,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          re_a,
  input  logic [AW-1:0] addr_a,
  output logic [DW-1:0] rdata_a,
  input  logic          re_b,
  input  logic [AW-1:0] addr_b,
  output logic [DW-1:0] rdata_b,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read ports, data held until the next read
  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a <= mem[addr_a];
    end
    if (re_b) begin
      rdata_b <= mem[addr_b];
    end
  end

endmodule

[rtl/kssc_upd.sv]
// ----------------------------------------------------------------------------
// kssc_upd
// Write-back stage: saturating add of the two table reads, clearing writes
// and the sticky saturation flag.
// ----------------------------------------------------------------------------
`include "k_subset_sum_counter_unit_assert.svh"

module kssc_upd #(
  parameter int AW = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  kssc_pkg::kssc_wr_ctl_t     ctl,
  input  logic [AW-1:0]              addr_in,
  input  logic [kssc_pkg::COUNT_W-1:0] rdata_a,
  input  logic [kssc_pkg::COUNT_W-1:0] rdata_b,
  output logic                       we,
  output logic [AW-1:0]              waddr,
  output logic [kssc_pkg::COUNT_W-1:0] wdata,
  output logic                       sat_flag
);

  logic                          p1_vld_r;
  logic [AW-1:0]                 p1_addr_r;
  logic                          sat_r;
  logic                          sat_nxt;
  logic [kssc_pkg::COUNT_W:0]    sum;
  logic                          carry;
  logic [kssc_pkg::COUNT_W-1:0]  sum_sat;

  // Track the entry whose reads are in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= ctl.upd_issue;
    end
  end

  always_ff @(posedge clk) begin
    p1_addr_r <= addr_in;
  end

  // Saturating add
  assign sum     = {1'b0, rdata_a} + {1'b0, rdata_b};
  assign carry   = sum[kssc_pkg::COUNT_W];
  assign sum_sat = carry ? '1 : sum[kssc_pkg::COUNT_W-1:0];

  // Select the write: clearing pass or update write-back
  always_comb begin
    we    = 1'b0;
    waddr = p1_addr_r;
    wdata = sum_sat;
    if (ctl.clr_wr) begin
      we    = 1'b1;
      waddr = addr_in;
      wdata = kssc_pkg::COUNT_W'(ctl.clr_one);
    end else if (p1_vld_r) begin
      we    = 1'b1;
    end
  end

  // Sticky saturation flag
  always_comb begin
    sat_nxt = sat_r;
    if (ctl.sat_clr) begin
      sat_nxt = 1'b0;
    end else if (p1_vld_r && carry) begin
      sat_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
    end else begin
      sat_r <= sat_nxt;
    end
  end

  assign sat_flag = sat_r;

  `KSSC_ASSERT_IMP(a_no_wr_clash, ctl.clr_wr, !p1_vld_r, "clear write collides with update")
  `KSSC_ASSERT_NXT(a_sat_sets, p1_vld_r && carry && !ctl.sat_clr, sat_r, "saturation missed")
  `KSSC_ASSERT_IMP(a_sat_cause, $rose(sat_r), $past(p1_vld_r && carry), "flag set without cause")

endmodule

[rtl/kssc_ctrl.sv]
// ----------------------------------------------------------------------------
// kssc_ctrl
// Sequencer: takes one word, clears the table before a first word, sweeps it
// by descending element count and partial sum, reads the result on a last word.
// ----------------------------------------------------------------------------
`include "k_subset_sum_counter_unit_assert.svh"

module kssc_ctrl #(
  parameter int MAX_K      = kssc_pkg::MAX_K_DEF,
  parameter int MAX_TARGET = kssc_pkg::MAX_TARGET_DEF,
  parameter int AW         = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kssc_pkg::VALUE_W-1:0]  in_value,
  input  logic                          in_first,
  input  logic                          in_last,
  input  logic [kssc_pkg::PICK_W-1:0]   pick_count,
  input  logic [kssc_pkg::GOAL_W-1:0]   goal_sum,
  input  logic                          out_free,
  output logic                          re_a,
  output logic [AW-1:0]                 addr_a,
  output logic                          re_b,
  output logic [AW-1:0]                 addr_b,
  output kssc_pkg::kssc_wr_ctl_t        wr_ctl,
  output logic                          res_ld,
  output logic                          res_fits
);

  localparam int COLS  = MAX_TARGET + 1;
  localparam int DEPTH = (MAX_K + 1) * COLS;
  localparam int JW    = $clog2(MAX_K + 1);
  localparam int SW    = $clog2(COLS);

  kssc_pkg::kssc_state_t state_r, state_nxt;

  logic [kssc_pkg::VALUE_W-1:0] val_r;
  logic                         first_r;
  logic                         last_r;
  logic                         busy_r, busy_nxt;
  logic [JW-1:0]                j_r, j_nxt;
  logic [SW-1:0]                s_r, s_nxt;
  logic [AW-1:0]                clr_cnt_r, clr_cnt_nxt;

  logic                         fits;
  logic                         do_upd;
  logic                         row_end;
  logic                         clr_end;
  logic [JW-1:0]                pick_j;
  logic [SW-1:0]                goal_s;
  logic [SW-1:0]                v_s;
  logic [AW-1:0]                sweep_a;
  logic [AW-1:0]                sweep_b;
  logic [AW-1:0]                res_addr;

  // Decode the registers and the held word
  assign fits    = (32'(pick_count) <= 32'(MAX_K)) && (32'(goal_sum) <= 32'(MAX_TARGET));
  assign do_upd  = fits && (32'(val_r) <= 32'(goal_sum)) && (pick_count != '0);
  assign pick_j  = JW'(32'(pick_count));
  assign goal_s  = SW'(32'(goal_sum));
  assign v_s     = SW'(val_r);
  assign row_end = (s_r == v_s);
  assign clr_end = (32'(clr_cnt_r) == DEPTH - 1);

  // Table addresses: row is element count, column is partial sum
  assign sweep_a  = AW'(32'(j_r) * COLS + 32'(s_r));
  assign sweep_b  = AW'(32'(j_r - JW'(1)) * COLS + 32'(s_r - v_s));
  assign res_addr = fits ? AW'(32'(pick_count) * COLS + 32'(goal_sum)) : '0;
  assign res_fits = fits;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kssc_pkg::ST_CLEAR: begin
        if (clr_end) begin
          state_nxt = busy_r ? kssc_pkg::ST_START : kssc_pkg::ST_IDLE;
        end
      end
      kssc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_first ? kssc_pkg::ST_CLEAR : kssc_pkg::ST_START;
        end
      end
      kssc_pkg::ST_START: begin
        state_nxt = do_upd ? kssc_pkg::ST_SWEEP : kssc_pkg::ST_FINISH;
      end
      kssc_pkg::ST_SWEEP: begin
        if (row_end && (j_r == JW'(1))) begin
          state_nxt = kssc_pkg::ST_DRAIN;
        end
      end
      kssc_pkg::ST_DRAIN:  state_nxt = kssc_pkg::ST_FINISH;
      kssc_pkg::ST_FINISH: state_nxt = last_r ? kssc_pkg::ST_RDWAIT : kssc_pkg::ST_IDLE;
      kssc_pkg::ST_RDWAIT: state_nxt = kssc_pkg::ST_RESULT;
      kssc_pkg::ST_RESULT: begin
        if (out_free) begin
          state_nxt = kssc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = kssc_pkg::ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready = 1'b0;
    re_a     = 1'b0;
    re_b     = 1'b0;
    addr_a   = sweep_a;
    addr_b   = sweep_b;
    wr_ctl   = '0;
    res_ld   = 1'b0;
    case (state_r)
      kssc_pkg::ST_CLEAR: begin
        addr_a         = clr_cnt_r;
        wr_ctl.clr_wr  = 1'b1;
        wr_ctl.clr_one = (clr_cnt_r == '0);
        wr_ctl.sat_clr = 1'b1;
      end
      kssc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      kssc_pkg::ST_SWEEP: begin
        re_a             = 1'b1;
        re_b             = 1'b1;
        wr_ctl.upd_issue = 1'b1;
      end
      kssc_pkg::ST_FINISH: begin
        addr_a = res_addr;
        re_a   = last_r;
      end
      kssc_pkg::ST_RESULT: begin
        res_ld = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Counters and word hold
  always_comb begin
    j_nxt       = j_r;
    s_nxt       = s_r;
    clr_cnt_nxt = clr_cnt_r;
    busy_nxt    = busy_r;
    case (state_r)
      kssc_pkg::ST_CLEAR: begin
        clr_cnt_nxt = clr_end ? '0 : clr_cnt_r + AW'(1);
      end
      kssc_pkg::ST_IDLE: begin
        busy_nxt = in_valid;
      end
      kssc_pkg::ST_START: begin
        j_nxt = pick_j;
        s_nxt = goal_s;
      end
      kssc_pkg::ST_SWEEP: begin
        if (row_end) begin
          j_nxt = j_r - JW'(1);
          s_nxt = goal_s;
        end else begin
          s_nxt = s_r - SW'(1);
        end
      end
      default: begin
        j_nxt = j_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= kssc_pkg::ST_CLEAR;
      busy_r    <= 1'b0;
      clr_cnt_r <= '0;
      j_r       <= '0;
      s_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      busy_r    <= busy_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      j_r       <= j_nxt;
      s_r       <= s_nxt;
    end
  end

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      val_r   <= in_value;
      first_r <= in_first;
      last_r  <= in_last;
    end
  end

  `KSSC_ASSERT_IMP(a_sweep_range, state_r == kssc_pkg::ST_SWEEP, (j_r != '0) && (s_r >= v_s), "sweep index out of range")
  `KSSC_ASSERT_IMP(a_first_clears, (state_r == kssc_pkg::ST_START) && busy_r && first_r, $past(state_r) == kssc_pkg::ST_CLEAR, "first word skipped clearing")
  `KSSC_ASSERT_NXT(a_clr_wrap, (state_r == kssc_pkg::ST_CLEAR) && clr_end, clr_cnt_r == '0, "clear counter not rewound")

endmodule

[rtl/k_subset_sum_counter_unit.sv]
// ----------------------------------------------------------------------------
// k_subset_sum_counter_unit
// Counts the k-element subsets of a streamed list that sum to a goal.
// ----------------------------------------------------------------------------
// Timing: the way table sits in one memory and is updated one entry per
// cycle through its single write port, and one word is taken at a time. A
// word with value v no larger than goal_sum, pick_count from 1 to MAX_K and
// goal_sum up to MAX_TARGET sweeps pick_count rows of goal_sum - v + 1
// entries in the SWEEP state; a word that updates nothing skips it. A word
// marked last then reads the count and loads the result register, and waits
// there while an earlier result word is still held. A word marked first is
// preceded by a clearing pass over all (MAX_K+1)*(MAX_TARGET+1) entries (2304
// at the defaults), and the same pass runs once after reset before the first
// word is taken. Configuration writes apply at once and belong between words,
// while no sweep is running.
module k_subset_sum_counter_unit #(
  parameter int MAX_K      = kssc_pkg::MAX_K_DEF,
  parameter int MAX_TARGET = kssc_pkg::MAX_TARGET_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [kssc_pkg::VALUE_W-1:0]    in_value,
  input  logic                            in_first,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kssc_pkg::COUNT_W-1:0]    out_ways,
  output logic                            out_overflow,
  input  logic                            cfg_we,
  input  logic [kssc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [kssc_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int DEPTH = (MAX_K + 1) * (MAX_TARGET + 1);
  localparam int AW    = $clog2(DEPTH);

  logic [kssc_pkg::PICK_W-1:0]  pick_r;
  logic [kssc_pkg::GOAL_W-1:0]  goal_r;
  logic                         out_valid_r;
  logic [kssc_pkg::COUNT_W-1:0] out_ways_r;
  logic                         out_overflow_r;

  logic                         out_free;
  logic                         re_a, re_b;
  logic [AW-1:0]                addr_a, addr_b;
  logic [kssc_pkg::COUNT_W-1:0] rdata_a, rdata_b;
  logic                         we;
  logic [AW-1:0]                waddr;
  logic [kssc_pkg::COUNT_W-1:0] wdata;
  logic                         sat_flag;
  logic                         res_ld;
  logic                         res_fits;
  kssc_pkg::kssc_wr_ctl_t       wr_ctl;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pick_r <= kssc_pkg::PICK_W'(1);
      goal_r <= kssc_pkg::GOAL_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        kssc_pkg::REG_PICK_COUNT: pick_r <= cfg_wdata[kssc_pkg::PICK_W-1:0];
        kssc_pkg::REG_GOAL_SUM:   goal_r <= cfg_wdata[kssc_pkg::GOAL_W-1:0];
        default: begin
          pick_r <= pick_r;
        end
      endcase
    end
  end

  kssc_ctrl #(
    .MAX_K      (MAX_K),
    .MAX_TARGET (MAX_TARGET),
    .AW         (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .in_first   (in_first),
    .in_last    (in_last),
    .pick_count (pick_r),
    .goal_sum   (goal_r),
    .out_free   (out_free),
    .re_a       (re_a),
    .addr_a     (addr_a),
    .re_b       (re_b),
    .addr_b     (addr_b),
    .wr_ctl     (wr_ctl),
    .res_ld     (res_ld),
    .res_fits   (res_fits)
  );

  kssc_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (kssc_pkg::COUNT_W)
  ) u_mem (
    .clk     (clk),
    .re_a    (re_a),
    .addr_a  (addr_a),
    .rdata_a (rdata_a),
    .re_b    (re_b),
    .addr_b  (addr_b),
    .rdata_b (rdata_b),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata)
  );

  kssc_upd #(
    .AW (AW)
  ) u_upd (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (wr_ctl),
    .addr_in  (addr_a),
    .rdata_a  (rdata_a),
    .rdata_b  (rdata_b),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .sat_flag (sat_flag)
  );

  // Result word register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ld) begin
      out_ways_r     <= res_fits ? rdata_a : '0;
      out_overflow_r <= sat_flag;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_ways     = out_ways_r;
  assign out_overflow = out_overflow_r;

endmodule
